FILE: rtl/stb_pkg.sv
// Shared types, operation codes and sizes for the software timer bank.
package stb_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int CH_W        = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    localparam logic [2:0] OP_TICK         = 3'd0;
    localparam logic [2:0] OP_START_SINGLE = 3'd1;
    localparam logic [2:0] OP_START_REPEAT = 3'd2;
    localparam logic [2:0] OP_STOP         = 3'd3;
    localparam logic [2:0] OP_QUERY        = 3'd4;
    localparam logic [2:0] OP_RESET        = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  timer_index;
        logic [31:0] timeout_ticks;
    } t_in_item;

    typedef struct packed {
        logic       expired;
        logic [7:0] echo_index;
    } t_out_item;

    typedef struct packed {
        logic            load_item;
        logic            exec;
        logic            sweep;
        logic            load_out;
        logic [CH_W-1:0] ch;
    } t_cmd;

endpackage

FILE: rtl/stb_ctrl.sv
// Controller state machine that sequences single-channel operations and tick sweeps.
module stb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [2:0]         i_operation,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output stb_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [stb_pkg::CH_W-1:0] LAST_CH =
        stb_pkg::CH_W'(stb_pkg::TIMER_COUNT - 1);

    logic [1:0]                r_state, n_state;
    logic [stb_pkg::CH_W-1:0]  r_ch, n_ch;
    logic                      r_out_valid, n_out_valid;
    logic                      w_accept;
    logic                      w_load_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load_item = w_accept;
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.sweep     = (r_state == S_SWEEP);
        o_cmd.load_out  = w_load_out;
        o_cmd.ch        = r_ch;
    end

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ch    = '0;
                    n_state = (i_operation == stb_pkg::OP_TICK) ? S_SWEEP : S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_SWEEP: begin
                if (r_ch == LAST_CH) begin
                    n_state = S_DONE;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/stb_datapath.sv
// Datapath holding the channel counts, timeouts and flags, and the result register.
module stb_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stb_pkg::t_in_item  i_item,
    input  stb_pkg::t_cmd      i_cmd,
    output stb_pkg::t_out_item o_item
);

    logic [31:0] r_count   [stb_pkg::TIMER_COUNT];
    logic [31:0] r_limit   [stb_pkg::TIMER_COUNT];
    logic [stb_pkg::TIMER_COUNT-1:0] r_expired;
    logic [stb_pkg::TIMER_COUNT-1:0] r_repeat;

    logic [2:0]  r_op;
    logic [7:0]  r_idx;
    logic [31:0] r_timeout;
    logic        r_res_expired;
    stb_pkg::t_out_item r_out;

    logic [stb_pkg::CH_W-1:0] w_addr;
    logic                     w_idx_ok;
    logic [31:0]              w_next;
    logic                     w_hit;

    // The sweep walks the channels; single operations use the captured index.
    assign w_addr   = i_cmd.sweep ? i_cmd.ch : r_idx[stb_pkg::CH_W-1:0];
    assign w_idx_ok = (r_idx < 8'(stb_pkg::TIMER_COUNT));
    assign w_next   = r_count[w_addr] + 32'd1;
    assign w_hit    = (w_next >= r_limit[w_addr]);
    assign o_item   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < stb_pkg::TIMER_COUNT; i++) begin
                r_count[i] <= '0;
                r_limit[i] <= '0;
            end
            r_expired <= '0;
            r_repeat  <= '0;
        end else if (i_cmd.sweep) begin
            r_count[w_addr] <= (w_hit && r_repeat[w_addr]) ? 32'd0 : w_next;
            if (w_hit) begin
                r_expired[w_addr] <= 1'b1;
            end
        end else if (i_cmd.exec && w_idx_ok) begin
            unique case (r_op) inside
                stb_pkg::OP_START_SINGLE, stb_pkg::OP_START_REPEAT: begin
                    r_count[w_addr]   <= '0;
                    r_limit[w_addr]   <= r_timeout;
                    r_expired[w_addr] <= 1'b0;
                    r_repeat[w_addr]  <= (r_op == stb_pkg::OP_START_REPEAT);
                end
                stb_pkg::OP_STOP: begin
                    r_count[w_addr]   <= '0;
                    r_expired[w_addr] <= 1'b0;
                    r_repeat[w_addr]  <= 1'b0;
                end
                stb_pkg::OP_QUERY: begin
                    r_expired[w_addr] <= 1'b0;
                end
                stb_pkg::OP_RESET: begin
                    r_count[w_addr]   <= '0;
                    r_expired[w_addr] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Captured word and result; payload only, so no reset is needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op          <= i_item.operation;
            r_idx         <= i_item.timer_index;
            r_timeout     <= i_item.timeout_ticks;
            r_res_expired <= 1'b0;
        end else if (i_cmd.exec) begin
            r_res_expired <= w_idx_ok && (r_op == stb_pkg::OP_QUERY) && r_expired[w_addr];
        end
        if (i_cmd.load_out) begin
            r_out.expired    <= r_res_expired;
            r_out.echo_index <= r_idx;
        end
    end

endmodule

FILE: rtl/software_timer_bank_unit.sv
// Top level of the software timer bank: controller, datapath and assertions.
// A bank of eight 32-bit timer channels driven by one word per operation. A tick word
// walks the channels one per clock through a single shared increment-and-compare unit,
// so it keeps the block busy until the last channel is swept; start, stop, reset, query
// and undefined operations pass through one execute state. Every word returns exactly
// one result word; a finished result sits in an output register, so the next word is
// taken while that result waits, and only the following result stalls behind it.
module software_timer_bank_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stb_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output stb_pkg::t_out_item o_out_item
);

    stb_pkg::t_cmd w_cmd;

    stb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_item.operation),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    stb_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (w_cmd),
        .o_item  (o_out_item)
    );

    // A tick word starts its sweep at the first channel on the next cycle.
    a_tick_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.operation == stb_pkg::OP_TICK)
        |=> (w_cmd.sweep && w_cmd.ch == '0))
        else $error("tick word did not start a sweep at channel zero");

    // Any other word is executed on the cycle after it is taken.
    a_single_op_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.operation != stb_pkg::OP_TICK)
        |=> w_cmd.exec)
        else $error("single-channel word was not executed");

    // The sweep and a single-channel update never share the state arrays.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.sweep && w_cmd.exec))
        else $error("sweep and single-channel update in the same cycle");

    // No new word is taken while the bank is being swept or updated.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.sweep || w_cmd.exec) |-> !o_in_ready)
        else $error("input taken while the bank is busy");

endmodule
